FILE: src/dhlt_pkg.sv
// Shared constants, types and functions for the DH link transform block.
package dhlt_pkg;

	localparam int CordicStages = 28;
	localparam int Stages = (CordicStages > 32) ? 32 : ((CordicStages < 0) ? 0 : CordicStages);
	localparam int XW = 34;
	localparam logic signed [XW-1:0] Gain = 34'sd652032874;
	localparam logic signed [XW-1:0] OneQ30 = 34'sd1073741824;
	localparam int AddrW = 4;

	localparam logic [AddrW-1:0] RegTheta = 4'd0;
	localparam logic [AddrW-1:0] RegAlpha = 4'd4;
	localparam logic [AddrW-1:0] RegLen = 4'd8;
	localparam logic [AddrW-1:0] RegOff = 4'd12;

	typedef struct packed {
		logic [31:0] joint_angle;
		logic [31:0] twist_angle;
		logic signed [31:0] length_delta;
		logic signed [31:0] offset_delta;
	} in_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m03;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m13;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [31:0] m23;
	} out_t;

	// One CORDIC lane: rotation vector, residual angle and quadrant flip.
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [32:0] z;
		logic flip;
	} lane_t;

	// Data that rides alongside the CORDIC lanes.
	typedef struct packed {
		logic signed [31:0] a;
		logic signed [31:0] d;
	} side_t;

	function automatic logic signed [32:0] atan_of(input int i);
		logic signed [32:0] t;
		case (i)
			0: t = 33'sd536870912;
			1: t = 33'sd316933406;
			2: t = 33'sd167458907;
			3: t = 33'sd85004756;
			4: t = 33'sd42667331;
			5: t = 33'sd21354465;
			6: t = 33'sd10679838;
			7: t = 33'sd5340245;
			8: t = 33'sd2670163;
			9: t = 33'sd1335087;
			10: t = 33'sd667544;
			11: t = 33'sd333772;
			12: t = 33'sd166886;
			13: t = 33'sd83443;
			14: t = 33'sd41722;
			15: t = 33'sd20861;
			16: t = 33'sd10430;
			17: t = 33'sd5215;
			18: t = 33'sd2608;
			19: t = 33'sd1304;
			20: t = 33'sd652;
			21: t = 33'sd326;
			22: t = 33'sd163;
			23: t = 33'sd81;
			24: t = 33'sd41;
			25: t = 33'sd20;
			26: t = 33'sd10;
			27: t = 33'sd5;
			28: t = 33'sd3;
			29: t = 33'sd1;
			30: t = 33'sd1;
			default: t = 33'sd0;
		endcase
		return t;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp30(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		if (v > OneQ30) begin
			r = OneQ30;
		end else if (v < -OneQ30) begin
			r = -OneQ30;
		end else begin
			r = v;
		end
		return r[31:0];
	endfunction

	// Rounded half up, floor shift by 30.
	function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd536870912;
		return t >>> 30;
	endfunction

endpackage

FILE: src/dhlt_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface dhlt_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/dhlt_cell.sv
// One CORDIC micro-rotation cell for both angle lanes, with its pipeline register.
module dhlt_cell (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic [4:0] idx,
	input logic vld_in,
	input dhlt_pkg::lane_t th_in,
	input dhlt_pkg::lane_t al_in,
	input dhlt_pkg::side_t side_in,
	output logic vld_s1,
	output dhlt_pkg::lane_t th_s1,
	output dhlt_pkg::lane_t al_s1,
	output dhlt_pkg::side_t side_s1
);
	dhlt_pkg::lane_t th_nx, al_nx;
	logic signed [32:0] at;

	assign at = dhlt_pkg::atan_of(int'(idx));

	always_comb begin
		th_nx = th_in;
		al_nx = al_in;
		if (!th_in.z[32]) begin
			th_nx.x = th_in.x - (th_in.y >>> idx);
			th_nx.y = th_in.y + (th_in.x >>> idx);
			th_nx.z = th_in.z - at;
		end else begin
			th_nx.x = th_in.x + (th_in.y >>> idx);
			th_nx.y = th_in.y - (th_in.x >>> idx);
			th_nx.z = th_in.z + at;
		end
		if (!al_in.z[32]) begin
			al_nx.x = al_in.x - (al_in.y >>> idx);
			al_nx.y = al_in.y + (al_in.x >>> idx);
			al_nx.z = al_in.z - at;
		end else begin
			al_nx.x = al_in.x + (al_in.y >>> idx);
			al_nx.y = al_in.y - (al_in.x >>> idx);
			al_nx.z = al_in.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s1 <= th_nx;
			al_s1 <= al_nx;
			side_s1 <= side_in;
		end
	end
endmodule

FILE: src/dh_link_transform.sv
// DH link transform top level: config registers, CORDIC cell chain, product stages.
//  channel   dir  payload                       transfer
//  in        in   joint/twist angle, deltas     valid & ready
//  out       out  m00..m23                      valid & ready
//  apb       in   four 32-bit offset registers  psel & penable & pwrite
// One pose per cycle while the sink takes results; the pipeline is the input register,
// the CORDIC cell chain (one cell per micro-rotation), then clamp, product and output registers.
// The whole pipeline advances together; it stalls only when its last stage
// holds a result the sink has not taken. Reset clears valid flags and offset registers.
module dh_link_transform (
	input logic clk,
	input logic arst_n,
	dhlt_stream_if.sink in_ch,
	dhlt_stream_if.source out_ch,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [dhlt_pkg::AddrW-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int N = dhlt_pkg::Stages;

	logic [31:0] th_off_q, al_off_q, len_off_q, d_off_q;
	logic en;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_off_q <= '0;
			al_off_q <= '0;
			len_off_q <= '0;
			d_off_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				dhlt_pkg::RegTheta: th_off_q <= pwdata;
				dhlt_pkg::RegAlpha: al_off_q <= pwdata;
				dhlt_pkg::RegLen: len_off_q <= pwdata;
				dhlt_pkg::RegOff: d_off_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			dhlt_pkg::RegTheta: prdata = th_off_q;
			dhlt_pkg::RegAlpha: prdata = al_off_q;
			dhlt_pkg::RegLen: prdata = len_off_q;
			dhlt_pkg::RegOff: prdata = d_off_q;
			default: prdata = '0;
		endcase
	end

	// Stage 1: angle sums, quadrant fold, saturated length and offset sums.
	logic v_s1;
	dhlt_pkg::lane_t th_s1, al_s1;
	dhlt_pkg::side_t sd_s1;
	logic [31:0] th_sum, al_sum, th_f, al_f;
	logic th_flip, al_flip;

	assign th_sum = th_off_q + in_ch.data.joint_angle;
	assign al_sum = al_off_q + in_ch.data.twist_angle;
	assign th_flip = th_sum[31] ^ th_sum[30];
	assign al_flip = al_sum[31] ^ al_sum[30];
	assign th_f = th_flip ? {~th_sum[31], th_sum[30:0]} : th_sum;
	assign al_f = al_flip ? {~al_sum[31], al_sum[30:0]} : al_sum;

	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			th_s1 <= '{x: dhlt_pkg::Gain, y: '0, z: {th_f[31], th_f}, flip: th_flip};
			al_s1 <= '{x: dhlt_pkg::Gain, y: '0, z: {al_f[31], al_f}, flip: al_flip};
			sd_s1.a <= dhlt_pkg::sat32(64'(signed'(len_off_q)) + 64'(in_ch.data.length_delta));
			sd_s1.d <= dhlt_pkg::sat32(64'(signed'(d_off_q)) + 64'(in_ch.data.offset_delta));
		end
	end

	// CORDIC cell chain.
	logic vc [N+1];
	dhlt_pkg::lane_t thc [N+1];
	dhlt_pkg::lane_t alc [N+1];
	dhlt_pkg::side_t sdc [N+1];

	assign vc[0] = v_s1;
	assign thc[0] = th_s1;
	assign alc[0] = al_s1;
	assign sdc[0] = sd_s1;

	for (genvar g = 0; g < N; g++) begin : g_cell
		dhlt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .idx(5'(g)),
			.vld_in(vc[g]), .th_in(thc[g]), .al_in(alc[g]), .side_in(sdc[g]),
			.vld_s1(vc[g+1]), .th_s1(thc[g+1]), .al_s1(alc[g+1]), .side_s1(sdc[g+1])
		);
	end

	// Stage 2: clamp and unfold.
	logic v_s2;
	logic signed [31:0] ct_s2, st_s2, ca_s2, sa_s2, a_s2, d_s2;
	logic signed [31:0] cx, cy, ax, ay;

	assign cx = dhlt_pkg::clamp30(thc[N].x);
	assign cy = dhlt_pkg::clamp30(thc[N].y);
	assign ax = dhlt_pkg::clamp30(alc[N].x);
	assign ay = dhlt_pkg::clamp30(alc[N].y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= vc[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ct_s2 <= thc[N].flip ? -cx : cx;
			st_s2 <= thc[N].flip ? -cy : cy;
			ca_s2 <= alc[N].flip ? -ax : ax;
			sa_s2 <= alc[N].flip ? -ay : ay;
			a_s2 <= sdc[N].a;
			d_s2 <= sdc[N].d;
		end
	end

	// Stage 3: products, rounding and saturation.
	logic v_s3;
	dhlt_pkg::out_t res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3.m00 <= ct_s2;
			res_s3.m01 <= 32'(-dhlt_pkg::rnd30(64'(st_s2) * 64'(ca_s2)));
			res_s3.m02 <= 32'(dhlt_pkg::rnd30(64'(st_s2) * 64'(sa_s2)));
			res_s3.m03 <= dhlt_pkg::sat32(dhlt_pkg::rnd30(64'(a_s2) * 64'(ct_s2)));
			res_s3.m10 <= st_s2;
			res_s3.m11 <= 32'(dhlt_pkg::rnd30(64'(ct_s2) * 64'(ca_s2)));
			res_s3.m12 <= 32'(-dhlt_pkg::rnd30(64'(ct_s2) * 64'(sa_s2)));
			res_s3.m13 <= dhlt_pkg::sat32(dhlt_pkg::rnd30(64'(a_s2) * 64'(st_s2)));
			res_s3.m21 <= sa_s2;
			res_s3.m22 <= ca_s2;
			res_s3.m23 <= d_s2;
		end
	end

	// Output register: pipeline moves whenever it is empty or being drained.
	logic out_v_q;
	dhlt_pkg::out_t out_q;

	assign en = !out_v_q || out_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= res_s3;
		end
	end
endmodule
